// File: rtl/core/pamd_pkg.sv
// Shared widths, register indexes, reset values and types for the PID motor drive.
`timescale 1ns / 1ps
package pamd_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int DUTY_BITS_DEF   = 16;

    localparam int GAIN_W     = 24;
    localparam int SUM_W      = 32;
    localparam int ILIM_W     = 31;
    localparam int OLIM_W     = 16;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ILIM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OLIM   = 3'd5;

    localparam logic [31:0]       TARGET_RST = 32'd2214;
    localparam logic [GAIN_W-1:0] KP_RST     = 24'd714190;
    localparam logic [GAIN_W-1:0] KI_RST     = 24'd119;
    localparam logic [GAIN_W-1:0] KD_RST     = 24'd1190253;
    localparam logic [ILIM_W-1:0] ILIM_RST   = 31'd704771000;
    localparam logic [OLIM_W-1:0] OLIM_RST   = 16'd19661;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } t_gains;

endpackage

// File: rtl/core/pamd_cfg.sv
// Configuration register file: setpoint, gains and limits.
`timescale 1ns / 1ps
module pamd_cfg
    import pamd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    output logic [SAMPLE_BITS-1:0] o_target,
    output t_gains                 o_gains,
    output logic [ILIM_W-1:0]      o_integral_limit,
    output logic [OLIM_W-1:0]      o_out_limit
);

    logic [SAMPLE_BITS-1:0] r_target;
    t_gains                 r_gains;
    logic [ILIM_W-1:0]      r_ilim;
    logic [OLIM_W-1:0]      r_olim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RST[SAMPLE_BITS-1:0];
            r_gains  <= '{kp: KP_RST, ki: KI_RST, kd: KD_RST};
            r_ilim   <= ILIM_RST;
            r_olim   <= OLIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TARGET: r_target   <= i_cfg_wdata[SAMPLE_BITS-1:0];
                REG_KP:     r_gains.kp <= i_cfg_wdata[GAIN_W-1:0];
                REG_KI:     r_gains.ki <= i_cfg_wdata[GAIN_W-1:0];
                REG_KD:     r_gains.kd <= i_cfg_wdata[GAIN_W-1:0];
                REG_ILIM:   r_ilim     <= i_cfg_wdata[ILIM_W-1:0];
                REG_OLIM:   r_olim     <= i_cfg_wdata[OLIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_target         = r_target;
    assign o_gains          = r_gains;
    assign o_integral_limit = r_ilim;
    assign o_out_limit      = r_olim;

endmodule

// File: rtl/core/pamd_err.sv
// Input register, error, error delta and clamped error sum with the loop state.
`timescale 1ns / 1ps
module pamd_err
    import pamd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int EW = SAMPLE_BITS + 1,
    localparam int DW = SAMPLE_BITS + 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_target,
    input  logic [ILIM_W-1:0]      i_integral_limit,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [EW-1:0]   o_err,
    output logic signed [DW-1:0]   o_derr,
    output logic signed [SUM_W-1:0] o_sum
);

    logic                    r_in_valid;
    logic [SAMPLE_BITS-1:0]  r_sample;
    logic                    r_valid;
    logic signed [EW-1:0]    r_err;
    logic signed [DW-1:0]    r_derr;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [EW-1:0]    r_prev_error;
    logic signed [SUM_W-1:0] r_error_sum;

    logic                    w_en_out;
    logic                    w_en_in;
    logic signed [EW-1:0]    w_err;
    logic signed [DW-1:0]    w_derr;
    logic signed [SUM_W:0]   w_sum_raw;
    logic signed [SUM_W:0]   w_lim;
    logic signed [SUM_W:0]   w_sum_c;

    assign w_en_out = !r_valid || i_ready;
    assign w_en_in  = !r_in_valid || w_en_out;
    assign o_ready  = w_en_in;

    assign w_err     = $signed({1'b0, i_target}) - $signed({1'b0, r_sample});
    assign w_derr    = DW'(w_err) - DW'(r_prev_error);
    assign w_sum_raw = (SUM_W+1)'(r_error_sum) + (SUM_W+1)'(w_err);
    assign w_lim     = signed'((SUM_W+1)'(i_integral_limit));

    always_comb begin
        if (w_sum_raw > w_lim) begin
            w_sum_c = w_lim;
        end else if (w_sum_raw < -w_lim) begin
            w_sum_c = -w_lim;
        end else begin
            w_sum_c = w_sum_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en_in) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_in && i_valid) begin
            r_sample <= i_sample;
        end
    end

    // loop state advances once per transfer leaving the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_prev_error <= '0;
            r_error_sum  <= '0;
        end else if (w_en_out) begin
            r_valid <= r_in_valid;
            if (r_in_valid) begin
                r_prev_error <= w_err;
                r_error_sum  <= w_sum_c[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out && r_in_valid) begin
            r_err  <= w_err;
            r_derr <= w_derr;
            r_sum  <= w_sum_c[SUM_W-1:0];
        end
    end

    assign o_valid = r_valid;
    assign o_err   = r_err;
    assign o_derr  = r_derr;
    assign o_sum   = r_sum;

endmodule

// File: rtl/core/pamd_mul.sv
// Gain multipliers: proportional, integral and derivative products.
`timescale 1ns / 1ps
module pamd_mul
    import pamd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int EW  = SAMPLE_BITS + 1,
    localparam int DW  = SAMPLE_BITS + 2,
    localparam int PW  = GAIN_W + 1 + EW,
    localparam int IW  = GAIN_W + 1 + SUM_W,
    localparam int DPW = GAIN_W + 1 + DW
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [EW-1:0]    i_err,
    input  logic signed [DW-1:0]    i_derr,
    input  logic signed [SUM_W-1:0] i_sum,
    input  t_gains                  i_gains,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [PW-1:0]    o_prop,
    output logic signed [IW-1:0]    o_integ,
    output logic signed [DPW-1:0]   o_deriv
);

    logic                  r_valid;
    logic signed [PW-1:0]  r_prop;
    logic signed [IW-1:0]  r_integ;
    logic signed [DPW-1:0] r_deriv;
    logic                  w_en;
    logic signed [PW-1:0]  w_prop;
    logic signed [IW-1:0]  w_integ;
    logic signed [DPW-1:0] w_deriv;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    assign w_prop  = $signed({1'b0, i_gains.kp}) * i_err;
    assign w_integ = $signed({1'b0, i_gains.ki}) * i_sum;
    assign w_deriv = $signed({1'b0, i_gains.kd}) * i_derr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_prop  <= w_prop;
            r_integ <= w_integ;
            r_deriv <= w_deriv;
        end
    end

    assign o_valid = r_valid;
    assign o_prop  = r_prop;
    assign o_integ = r_integ;
    assign o_deriv = r_deriv;

endmodule

// File: rtl/core/pamd_out.sv
// Product sum, duty scaling, drive clamp and forward/reverse split into the result register.
`timescale 1ns / 1ps
module pamd_out
    import pamd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int DUTY_BITS   = DUTY_BITS_DEF,
    localparam int EW   = SAMPLE_BITS + 1,
    localparam int DW   = SAMPLE_BITS + 2,
    localparam int PW   = GAIN_W + 1 + EW,
    localparam int IW   = GAIN_W + 1 + SUM_W,
    localparam int DPW  = GAIN_W + 1 + DW,
    localparam int ACCW = IW + 2,
    localparam int GAIN_SHIFT = GAIN_W - DUTY_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [PW-1:0]  i_prop,
    input  logic signed [IW-1:0]  i_integ,
    input  logic signed [DPW-1:0] i_deriv,
    input  logic [OLIM_W-1:0]     i_out_limit,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DUTY_BITS-1:0]  o_duty_forward,
    output logic [DUTY_BITS-1:0]  o_duty_reverse
);

    localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};

    logic                   r_valid;
    logic [DUTY_BITS-1:0]   r_fwd;
    logic [DUTY_BITS-1:0]   r_rev;
    logic                   w_en;
    logic signed [ACCW-1:0] w_acc;
    logic signed [ACCW-1:0] w_drive;
    logic [DUTY_BITS-1:0]   w_lim;
    logic signed [ACCW-1:0] w_lim_s;
    logic signed [ACCW-1:0] w_clamped;
    logic signed [ACCW-1:0] w_neg;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    assign w_acc   = ACCW'(i_prop) + ACCW'(i_integ) + ACCW'(i_deriv);
    assign w_drive = w_acc >>> GAIN_SHIFT;
    assign w_lim   = (i_out_limit > OLIM_W'(DUTY_MAX)) ? DUTY_MAX
                                                      : i_out_limit[DUTY_BITS-1:0];
    assign w_lim_s = signed'(ACCW'(w_lim));

    always_comb begin
        if (w_drive > w_lim_s) begin
            w_clamped = w_lim_s;
        end else if (w_drive < -w_lim_s) begin
            w_clamped = -w_lim_s;
        end else begin
            w_clamped = w_drive;
        end
    end

    assign w_neg = -w_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            if (w_clamped[ACCW-1]) begin
                r_fwd <= '0;
                r_rev <= w_neg[DUTY_BITS-1:0];
            end else begin
                r_fwd <= w_clamped[DUTY_BITS-1:0];
                r_rev <= '0;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_duty_forward = r_fwd;
    assign o_duty_reverse = r_rev;

    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_fwd == '0 || r_rev == '0))
        else $error("forward and reverse duty both nonzero");

    a_fwd_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_fwd <= w_lim))
        else $error("forward duty above drive limit");

    a_rev_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_rev <= w_lim))
        else $error("reverse duty above drive limit");

endmodule

// File: rtl/core/pid_angle_motor_drive_top.sv
// Top level of the PID angle controller with forward/reverse PWM duty outputs.
//
//  port group   dir  payload (low bit up)                    transfer when
//  s_axis       in   adc_sample                              tvalid & tready
//  m_axis       out  duty_forward, duty_reverse              tvalid & tready
//  i_cfg_*      in   register index, write data              i_cfg_we
//
//  One sample per cycle sustained while m_axis is not stalled; the result is registered in order
//  through the register stages: input reg, error/sum state, multipliers, sum/clamp/result reg.
//  The error sum and previous error update together in the second stage.
//  Reset clears all valids and the loop state and loads default registers.
//  Each stage holds when the one after it is full and stalled; stalls ripple back.
`timescale 1ns / 1ps
module pid_angle_motor_drive_top
    import pamd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int DUTY_BITS   = DUTY_BITS_DEF,
    localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((2 * DUTY_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // adc_sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // duty_forward, duty_reverse
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int EW  = SAMPLE_BITS + 1;
    localparam int DW  = SAMPLE_BITS + 2;
    localparam int PW  = GAIN_W + 1 + EW;
    localparam int IW  = GAIN_W + 1 + SUM_W;
    localparam int DPW = GAIN_W + 1 + DW;

    logic [SAMPLE_BITS-1:0]  w_target;
    t_gains                  w_gains;
    logic [ILIM_W-1:0]       w_ilim;
    logic [OLIM_W-1:0]       w_olim;

    logic                    w_err_valid;
    logic                    w_mul_ready;
    logic signed [EW-1:0]    w_err;
    logic signed [DW-1:0]    w_derr;
    logic signed [SUM_W-1:0] w_sum;

    logic                    w_mul_valid;
    logic                    w_out_ready;
    logic signed [PW-1:0]    w_prop;
    logic signed [IW-1:0]    w_integ;
    logic signed [DPW-1:0]   w_deriv;

    logic [DUTY_BITS-1:0]    w_fwd;
    logic [DUTY_BITS-1:0]    w_rev;

    pamd_cfg #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_target         (w_target),
        .o_gains          (w_gains),
        .o_integral_limit (w_ilim),
        .o_out_limit      (w_olim)
    );

    pamd_err #(.SAMPLE_BITS(SAMPLE_BITS)) u_err (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_sample         (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_target         (w_target),
        .i_integral_limit (w_ilim),
        .o_valid          (w_err_valid),
        .i_ready          (w_mul_ready),
        .o_err            (w_err),
        .o_derr           (w_derr),
        .o_sum            (w_sum)
    );

    pamd_mul #(.SAMPLE_BITS(SAMPLE_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_err_valid),
        .o_ready (w_mul_ready),
        .i_err   (w_err),
        .i_derr  (w_derr),
        .i_sum   (w_sum),
        .i_gains (w_gains),
        .o_valid (w_mul_valid),
        .i_ready (w_out_ready),
        .o_prop  (w_prop),
        .o_integ (w_integ),
        .o_deriv (w_deriv)
    );

    pamd_out #(.SAMPLE_BITS(SAMPLE_BITS), .DUTY_BITS(DUTY_BITS)) u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_mul_valid),
        .o_ready        (w_out_ready),
        .i_prop         (w_prop),
        .i_integ        (w_integ),
        .i_deriv        (w_deriv),
        .i_out_limit    (w_olim),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_duty_forward (w_fwd),
        .o_duty_reverse (w_rev)
    );

    assign m_axis_tdata = M_TDATA_W'({w_rev, w_fwd});

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the PID angle motor drive: directed and random samples, scoreboard.
`timescale 1ns / 1ps
module tb_top;
    import pamd_pkg::*;

    typedef struct packed {
        logic [15:0] rev;
        logic [15:0] fwd;
    } t_duty_pair;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;   // adc_sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;   // duty_forward, duty_reverse
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    pid_angle_motor_drive_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // controller mirror
    logic [11:0]       cfg_target;
    logic [GAIN_W-1:0] cfg_kp;
    logic [GAIN_W-1:0] cfg_ki;
    logic [GAIN_W-1:0] cfg_kd;
    logic [ILIM_W-1:0] cfg_ilim;
    logic [OLIM_W-1:0] cfg_olim;
    longint            err_prev;
    longint            err_sum;

    t_duty_pair duty_expected_q[$];
    t_duty_pair exp_duty;
    int         mismatch_count;
    int         results_seen;
    int         samples_sent;
    int         cfg_writes;
    bit         src_idle_on;
    bit         snk_idle_on;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_duty_pair pid_predict(input logic [11:0] sample);
        longint     e;
        longint     de;
        longint     s;
        longint     acc;
        longint     drv;
        longint     lim;
        longint     mag;
        t_duty_pair r;
        e = longint'(cfg_target) - longint'(sample);
        de = e - err_prev;
        lim = longint'(cfg_ilim);
        s = err_sum + e;
        if (s > lim) s = lim;
        else if (s < -lim) s = -lim;
        acc = longint'(cfg_kp) * e + longint'(cfg_ki) * s + longint'(cfg_kd) * de;
        drv = acc >>> 8;
        lim = longint'(cfg_olim);
        if (drv > lim) drv = lim;
        else if (drv < -lim) drv = -lim;
        if (drv >= 0) begin
            r.fwd = drv[15:0];
            r.rev = 16'd0;
        end else begin
            mag = -drv;
            r.fwd = 16'd0;
            r.rev = mag[15:0];
        end
        err_prev = e;
        err_sum = s;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (duty_expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result fwd=%0d rev=%0d",
                                          m_axis_tdata[15:0], m_axis_tdata[31:16]));
            end else begin
                exp_duty = duty_expected_q.pop_front();
                if (m_axis_tdata[15:0] !== exp_duty.fwd || m_axis_tdata[31:16] !== exp_duty.rev)
                    report_mismatch($sformatf("fwd exp %0d got %0d, rev exp %0d got %0d",
                                              exp_duty.fwd, m_axis_tdata[15:0],
                                              exp_duty.rev, m_axis_tdata[31:16]));
            end
        end
    end

    // result sink with random back-pressure
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = snk_idle_on ? $urandom_range(0, 11) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_sample(input logic [15:0] word);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 11) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        duty_expected_q.push_back(pid_predict(word[11:0]));
        samples_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (duty_expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_writes++;
        case (idx)
            REG_TARGET: cfg_target = val[11:0];
            REG_KP:     cfg_kp     = val[GAIN_W-1:0];
            REG_KI:     cfg_ki     = val[GAIN_W-1:0];
            REG_KD:     cfg_kd     = val[GAIN_W-1:0];
            REG_ILIM:   cfg_ilim   = val[ILIM_W-1:0];
            REG_OLIM:   cfg_olim   = val[OLIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic test_reset_defaults();
        send_sample(16'd0);
        send_sample(16'd4095);
        send_sample(16'd2214);
        send_sample(16'hF000 | 16'd123);
        send_sample(16'd2000);
        wait_drained();
    endtask

    task automatic test_output_limits();
        write_reg(REG_OLIM, 31'd0);
        send_sample(16'd0);
        send_sample(16'd4095);
        wait_drained();
        write_reg(REG_KP, 31'h7FFFFFFF);
        write_reg(REG_OLIM, 31'h7FFF0000 | 31'hFFFF);
        send_sample(16'd0);
        send_sample(16'd4095);
        send_sample(16'd4095);
        wait_drained();
    endtask

    task automatic test_integrator_clamp();
        write_reg(REG_TARGET, 31'h7FFFF000 | 31'd4095);
        write_reg(REG_KP, 31'd0);
        write_reg(REG_KD, 31'd0);
        write_reg(REG_KI, 31'hFFFFFF);
        write_reg(REG_ILIM, 31'd0);
        send_sample(16'd0);
        send_sample(16'd0);
        wait_drained();
        write_reg(REG_ILIM, 31'h7FFFFFFF);
        write_reg(REG_OLIM, 31'd60000);
        send_sample(16'd0);
        send_sample(16'd0);
        send_sample(16'd4000);
        wait_drained();
        write_reg(REG_ILIM, 31'd100);
        send_sample(16'd4095);
        send_sample(16'd4095);
        wait_drained();
        // indexes past the register list change nothing
        write_reg(3'd6, 31'h7FFFFFFF);
        write_reg(3'd7, 31'h2AAAAAAA);
        write_reg(REG_TARGET, 31'd0);
        send_sample(16'd4095);
        send_sample(16'd0);
        wait_drained();
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_value(input int width, input int typical);
        logic [CFG_DATA_W-1:0] full;
        full = (width >= CFG_DATA_W) ? {CFG_DATA_W{1'b1}} : ((31'd1 << width) - 31'd1);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return full;
            2:       return CFG_DATA_W'($urandom()) & full;
            default: return CFG_DATA_W'($urandom_range(0, typical));
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 4095;
            2, 3, 4, 5: begin
                v = int'(cfg_target) + $urandom_range(0, 200) - 100;
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
            end
            default: v = $urandom_range(0, 4095);
        endcase
        return 16'(v);
    endfunction

    task automatic test_random_phases();
        for (int ph = 0; ph < 10; ph++) begin
            wait_drained();
            write_reg(REG_TARGET, pick_value(12, 4095));
            write_reg(REG_KP, pick_value(GAIN_W, 1 << 21));
            write_reg(REG_KI, pick_value(GAIN_W, 2000));
            write_reg(REG_KD, pick_value(GAIN_W, 1 << 21));
            write_reg(REG_ILIM, pick_value(ILIM_W, 50000));
            write_reg(REG_OLIM, pick_value(OLIM_W, 65535));
            for (int n = 0; n < 200; n++) begin
                if (n % 50 == 0) begin
                    src_idle_on = ($urandom_range(0, 3) != 0);
                    snk_idle_on = ($urandom_range(0, 3) != 0);
                end
                if (n == 100) wait_drained();
                send_sample(pick_sample());
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        src_idle_on   = 1'b1;
        snk_idle_on   = 1'b1;
        mismatch_count = 0;
        results_seen  = 0;
        samples_sent  = 0;
        cfg_writes    = 0;
        cfg_target    = TARGET_RST[11:0];
        cfg_kp        = KP_RST;
        cfg_ki        = KI_RST;
        cfg_kd        = KD_RST;
        cfg_ilim      = ILIM_RST;
        cfg_olim      = OLIM_RST;
        err_prev      = 0;
        err_sum       = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_output_limits();
        test_integrator_clamp();
        test_random_phases();
        wait_drained();

        $display("Ran %0d samples with %0d register writes; %0d results checked, %0d mismatches.",
                 samples_sent, cfg_writes, results_seen, mismatch_count);
        if (mismatch_count == 0 && duty_expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
